// ----- rtl/prim_mst_dense_matrix_macros.svh -----
// Assertion macros shared by the checker.
`ifndef PRIM_MST_DENSE_MATRIX_MACROS_SVH
`define PRIM_MST_DENSE_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PMST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PMST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pmst_pkg.sv -----
// Package: types and fixed field layout of the Prim spanning tree block.
`timescale 1ns / 1ps
`default_nettype none
package pmst_pkg;

  localparam int unsigned VTX_W     = 6;
  localparam int unsigned WT_IN_W   = 16;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned M_DATA_W  = 32;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_INIT     = 8'b0000_0100,
    S_SEL      = 8'b0000_1000,
    S_RELAX    = 8'b0001_0000,
    S_OUT_RD   = 8'b0010_0000,
    S_OUT_LD   = 8'b0100_0000,
    S_OUT_HOLD = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/pmst_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pmst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/prim_mst_dense_matrix.sv -----
// Top level: matrix loader and Prim spanning tree engine.
//
// Use: matrix entries arrive on the s_ channel, one transaction per cycle while
// s_tready is high; tdata = {weight, col, row}, tlast marks the final entry.
// An entry outside MAX_VERTICES rows/cols is dropped; tlast still starts a run.
// The cfg_ channel writes vertex_count (0 acts as 1, above MAX_VERTICES saturates).
// After the last entry, s_tready drops and the run goes through two RAMs:
// the weight matrix and a per-vertex tree table {in_tree, parent, key}.
// Run for n vertices: table init, then each round is a select scan and a
// relaxation scan of the chosen row; up to n rounds plus one final scan,
// bound by the one read port of each RAM. Results then leave one at a time,
// each after the last is taken, vertex 1 to n-1, tlast on the last;
// tuser = connected.
// A stalled receiver holds the result in its output register; nothing is lost.
// Reset: a clearing pass zeroes the matrix with s_tready low; cfg writes
// are taken at all times. Entries survive runs.
`timescale 1ns / 1ps
`default_nettype none
module prim_mst_dense_matrix
  import pmst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // row[5:0], col[11:6], weight[27:12], zeros
  input  wire logic                s_tlast,   // last
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata,   // vertex[5:0], parent_vertex[11:6],
                                              // edge_weight[27:12], zeros
  output logic      [0:0]          m_tuser,   // connected
  output logic                     m_tlast,   // end_of_run
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_data   // vertex_count
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned CW     = $clog2(MAX_VERTICES + 1);
  localparam int unsigned MDEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW     = $clog2(MDEPTH);
  localparam int unsigned KW     = WEIGHT_BITS + 1;
  localparam int unsigned TW     = 1 + VW + KW;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     n_run;
  logic              pipe_vld;
  logic [VW-1:0]     pipe_idx;
  logic [KW-1:0]     best;
  logic [VW-1:0]     best_idx;
  logic              found;
  logic [VW-1:0]     u;
  logic [AW-1:0]     clr_addr;
  logic [CFG_W-1:0]  vertex_count;
  logic [VTX_W-1:0]  out_vtx;
  logic [VTX_W-1:0]  out_par;
  logic [WT_IN_W-1:0] out_wt;
  logic              out_conn;
  logic              out_last;

  logic [VTX_W-1:0]   in_row, in_col;
  logic [WT_IN_W-1:0] in_wt;
  logic               in_ok, acc_in, issue, pass_done;
  logic [AW-1:0]      in_addr, m_raddr, m_waddr;
  logic [WEIGHT_BITS-1:0] wt_st, m_wdata, m_rdata;
  logic               m_we, t_we;
  logic [VW-1:0]      t_waddr;
  logic [TW-1:0]      t_wdata, t_rdata;
  logic               t_it, it_new, upd;
  logic [VW-1:0]      t_par;
  logic [KW-1:0]      t_key;
  logic [CW-1:0]      n_start;

  assign in_row = s_tdata[5:0];
  assign in_col = s_tdata[11:6];
  assign in_wt  = s_tdata[27:12];
  assign wt_st  = WEIGHT_BITS'({{WEIGHT_BITS{1'b0}}, in_wt});
  assign in_ok  = ({1'b0, in_row} < CFG_W'(MAX_VERTICES)) &&
                  ({1'b0, in_col} < CFG_W'(MAX_VERTICES));
  assign in_addr = AW'(AW'(in_row[VW-1:0]) * AW'(MAX_VERTICES) + AW'(in_col[VW-1:0]));

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = s_tvalid && s_tready;

  always_comb begin
    if (vertex_count == '0) begin
      n_start = CW'(1);
    end else if (vertex_count > CFG_W'(MAX_VERTICES)) begin
      n_start = CW'(MAX_VERTICES);
    end else begin
      n_start = CW'(vertex_count);
    end
  end

  // scan control shared by the select and relax passes
  assign issue     = ((state == S_SEL) || (state == S_RELAX)) && (cnt < n_run);
  assign pass_done = (cnt == n_run) && !pipe_vld;

  assign t_key = t_rdata[KW-1:0];
  assign t_par = t_rdata[KW+VW-1:KW];
  assign t_it  = t_rdata[TW-1];

  // u joins the tree as its own row is scanned
  assign it_new = t_it || (pipe_idx == u);
  assign upd    = (m_rdata != '0) && !it_new && ({1'b0, m_rdata} < t_key);

  assign m_we    = (state == S_CLEAR) || (acc_in && in_ok);
  assign m_waddr = (state == S_CLEAR) ? clr_addr : in_addr;
  assign m_wdata = (state == S_CLEAR) ? '0 : wt_st;
  assign m_raddr = AW'(AW'(u) * AW'(MAX_VERTICES) + AW'(cnt[VW-1:0]));

  always_comb begin
    if (state == S_INIT) begin
      t_we    = 1'b1;
      t_waddr = cnt[VW-1:0];
      t_wdata = {1'b0, {VW{1'b0}}, (cnt == '0) ? {KW{1'b0}} : KEY_INF};
    end else begin
      t_we    = (state == S_RELAX) && pipe_vld;
      t_waddr = pipe_idx;
      t_wdata = {it_new, upd ? u : t_par, upd ? {1'b0, m_rdata} : t_key};
    end
  end

  pmst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MDEPTH)) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  pmst_ram #(.WIDTH(TW), .DEPTH(MAX_VERTICES)) u_tree (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (cnt[VW-1:0]),
    .rdata (t_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= '0;
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= issue;
      pipe_idx <= cnt[VW-1:0];
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MDEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_in && s_tlast) begin
            n_run <= n_start;
            cnt   <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (cnt == n_run - CW'(1)) begin
            cnt   <= '0;
            best  <= KEY_INF;
            found <= 1'b0;
            state <= S_SEL;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SEL: begin
          if (pipe_vld && !t_it && (t_key < best)) begin
            best     <= t_key;
            best_idx <= pipe_idx;
            found    <= 1'b1;
          end
          if (pass_done) begin
            if (found) begin
              u     <= best_idx;
              cnt   <= '0;
              state <= S_RELAX;
            end else if (n_run > CW'(1)) begin
              cnt   <= CW'(1);
              state <= S_OUT_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RELAX: begin
          if (pass_done) begin
            cnt   <= '0;
            best  <= KEY_INF;
            found <= 1'b0;
            state <= S_SEL;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_vtx  <= VTX_W'(cnt);
          out_conn <= t_it;
          out_par  <= t_it ? VTX_W'(t_par) : '0;
          out_wt   <= t_it ? WT_IN_W'({{WT_IN_W{1'b0}}, t_key}) : '0;
          out_last <= (cnt == n_run - CW'(1));
          state    <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (m_tready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + CW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT_HOLD);
  assign m_tdata  = {4'b0000, out_wt, out_par, out_vtx};
  assign m_tuser  = out_conn;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

// ----- rtl/pmst_chk.sv -----
// Port-level checker for the spanning tree block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "prim_mst_dense_matrix_macros.svh"
module pmst_chk
  import pmst_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                s_tlast,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata,
  input wire logic [0:0]          m_tuser
);

  `PMST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
  `PMST_ASSERT_NOW(a_no_load_in_out, m_tvalid, !s_tready, "entry load during result phase")
  `PMST_ASSERT_NEXT(a_last_starts_run, s_tvalid && s_tready && s_tlast, !s_tready, "run did not start on last entry")
  `PMST_ASSERT_NOW(a_vertex_nonzero, m_tvalid, m_tdata[5:0] != '0, "result for vertex zero")
  `PMST_ASSERT_NOW(a_unreached_zero, m_tvalid && !m_tuser[0], m_tdata[27:6] == '0, "unreached vertex has parent or weight")

endmodule

bind prim_mst_dense_matrix pmst_chk u_pmst_chk (.*);
`default_nettype wire
